// ----- rtl/core/alle_pkg.sv -----
package alle_pkg;

    localparam int SLOTS   = 64;
    localparam int PTR_W   = 7;
    localparam int ADDR_W  = $clog2(SLOTS);
    localparam int DATA_W  = 32;
    localparam int QDEPTH  = 2;
    localparam int QA_W    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        CMD_INS_BEFORE = 2'd0,
        CMD_INS_AFTER  = 2'd1,
        CMD_DELETE     = 2'd2,
        CMD_SEARCH     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_SLOT  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_W1,
        S_W2,
        S_SR_ISSUE,
        S_SR_CMP,
        S_DONE
    } state_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              slot_ok;
        logic [PTR_W-1:0]  slot;
        logic [DATA_W-1:0] value;
    } item_t;

    typedef struct packed {
        status_t           status;
        logic [PTR_W-1:0]  rslot;
        logic [DATA_W-1:0] removed;
        logic [PTR_W-1:0]  count;
        logic [PTR_W-1:0]  head;
        logic [PTR_W-1:0]  tail;
    } result_t;

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [PTR_W-1:0] s);
        logic [PTR_W-1:0] tmp;
        tmp = s - PTR_W'(1);
        return tmp[ADDR_W-1:0];
    endfunction

    // successor of a slot in the free chain as it stands after reset
    function automatic logic [PTR_W-1:0] chain_next(input logic [ADDR_W-1:0] a);
        if (a == ADDR_W'(SLOTS - 1))
            return '0;
        else
            return PTR_W'(a) + PTR_W'(2);
    endfunction

endpackage

// ----- rtl/core/alle_ram.sv -----
module alle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/alle_front.sv -----
module alle_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 command,
    input  logic [alle_pkg::PTR_W-1:0] slot,
    input  logic [alle_pkg::DATA_W-1:0] value,
    output logic                       item_valid,
    output alle_pkg::item_t            item,
    input  logic                       item_take
);

    alle_pkg::item_t             q_reg [alle_pkg::QDEPTH];
    logic [alle_pkg::QA_W-1:0]   wptr_reg, wptr_next;
    logic [alle_pkg::QA_W-1:0]   rptr_reg, rptr_next;
    logic [alle_pkg::QA_W:0]     cnt_reg, cnt_next;
    alle_pkg::item_t             new_item;
    logic                        enq;
    logic                        deq;

    // range check of the target slot is done up front
    always_comb
    begin
        new_item.cmd     = alle_pkg::cmd_t'(command);
        new_item.slot_ok = (slot != '0) && (slot <= alle_pkg::PTR_W'(alle_pkg::SLOTS));
        new_item.slot    = slot;
        new_item.value   = value;
    end

    assign full       = (cnt_reg == (alle_pkg::QA_W+1)'(alle_pkg::QDEPTH));
    assign item_valid = (cnt_reg != '0);
    assign item       = q_reg[rptr_reg];
    assign enq        = push && !full;
    assign deq        = item_take && item_valid;

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (enq)
        begin
            wptr_next = (wptr_reg == alle_pkg::QA_W'(alle_pkg::QDEPTH - 1)) ? '0
                        : wptr_reg + alle_pkg::QA_W'(1);
        end
        if (deq)
        begin
            rptr_next = (rptr_reg == alle_pkg::QA_W'(alle_pkg::QDEPTH - 1)) ? '0
                        : rptr_reg + alle_pkg::QA_W'(1);
        end
        if (enq && !deq)
        begin
            cnt_next = cnt_reg + (alle_pkg::QA_W+1)'(1);
        end
        else if (deq && !enq)
        begin
            cnt_next = cnt_reg - (alle_pkg::QA_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wptr_reg] <= new_item;
        end
    end

endmodule

// ----- rtl/core/alle_back.sv -----
module alle_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    input  alle_pkg::item_t item,
    output logic            item_take,
    output logic            res_valid,
    output alle_pkg::result_t res,
    input  logic            pop
);

    localparam int PW = alle_pkg::PTR_W;
    localparam int AW = alle_pkg::ADDR_W;
    localparam int DW = alle_pkg::DATA_W;

    alle_pkg::state_t   state_reg, state_next;
    alle_pkg::item_t    item_reg, item_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [PW-1:0]      tail_reg, tail_next;
    logic [PW-1:0]      free_reg, free_next;
    logic [PW-1:0]      cnt_reg, cnt_next;
    logic [alle_pkg::SLOTS-1:0] used_reg, used_next;
    logic [alle_pkg::SLOTS-1:0] nwr_reg, nwr_next;
    logic [PW-1:0]      n_reg, n_next;
    logic [PW-1:0]      p_reg, p_next;
    logic [PW-1:0]      q_reg, q_next;
    logic [PW-1:0]      fnext_reg, fnext_next;
    logic [PW-1:0]      cur_reg, cur_next;
    logic [PW-1:0]      steps_reg, steps_next;
    alle_pkg::status_t  st_reg, st_next;
    logic [PW-1:0]      rs_reg, rs_next;
    logic [DW-1:0]      rm_reg, rm_next;
    logic [AW-1:0]      nra_reg;
    alle_pkg::result_t  res_reg, res_next;
    logic               res_valid_reg, res_valid_next;

    logic               d_we, n_we, p_we;
    logic [AW-1:0]      d_waddr, n_waddr, p_waddr;
    logic [AW-1:0]      d_raddr, n_raddr, p_raddr;
    logic [DW-1:0]      d_wdata, d_rdata;
    logic [PW-1:0]      n_wdata, n_rdata, p_wdata, p_rdata;
    logic [PW-1:0]      next_val;
    logic [AW-1:0]      taddr;

    alle_ram #(.WIDTH(DW), .DEPTH(alle_pkg::SLOTS)) u_data (
        .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
        .raddr(d_raddr), .rdata(d_rdata)
    );

    alle_ram #(.WIDTH(PW), .DEPTH(alle_pkg::SLOTS)) u_next (
        .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    alle_ram #(.WIDTH(PW), .DEPTH(alle_pkg::SLOTS)) u_prev (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    // never written link entries read as the free chain from reset
    assign next_val  = nwr_reg[nra_reg] ? n_rdata : alle_pkg::chain_next(nra_reg);
    assign taddr     = alle_pkg::slot_addr(item_reg.slot);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_next      = free_reg;
        cnt_next       = cnt_reg;
        used_next      = used_reg;
        nwr_next       = nwr_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        fnext_next     = fnext_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        st_next        = st_reg;
        rs_next        = rs_reg;
        rm_next        = rm_reg;
        res_next       = res_reg;
        res_valid_next = (pop && res_valid_reg) ? 1'b0 : res_valid_reg;
        item_take      = 1'b0;
        d_we = 1'b0; d_waddr = '0; d_wdata = item_reg.value;
        n_we = 1'b0; n_waddr = '0; n_wdata = '0;
        p_we = 1'b0; p_waddr = '0; p_wdata = '0;
        d_raddr = taddr;
        n_raddr = taddr;
        p_raddr = taddr;

        case (state_reg)
            alle_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    item_take  = 1'b1;
                    item_next  = item;
                    st_next    = alle_pkg::ST_OK;
                    rs_next    = '0;
                    rm_next    = '0;
                    cur_next   = head_reg;
                    steps_next = '0;
                    state_next = alle_pkg::S_RD1;
                    case (item.cmd)
                        alle_pkg::CMD_INS_BEFORE, alle_pkg::CMD_INS_AFTER:
                        begin
                            if (free_reg == '0)
                            begin
                                st_next    = alle_pkg::ST_FULL;
                                state_next = alle_pkg::S_DONE;
                            end
                            else if (cnt_reg != '0 &&
                                     !(item.slot_ok && used_reg[alle_pkg::slot_addr(item.slot)]))
                            begin
                                st_next    = alle_pkg::ST_BAD_SLOT;
                                state_next = alle_pkg::S_DONE;
                            end
                        end
                        alle_pkg::CMD_DELETE:
                        begin
                            if (!(item.slot_ok && used_reg[alle_pkg::slot_addr(item.slot)]))
                            begin
                                st_next    = alle_pkg::ST_BAD_SLOT;
                                state_next = alle_pkg::S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = alle_pkg::S_SR_ISSUE;
                        end
                    endcase
                end
            end

            alle_pkg::S_RD1:
            begin
                n_next = free_reg;
                if (item_reg.cmd != alle_pkg::CMD_DELETE)
                begin
                    n_raddr = alle_pkg::slot_addr(free_reg);
                end
                state_next = alle_pkg::S_RD2;
            end

            alle_pkg::S_RD2:
            begin
                p_next = p_rdata;
                if (item_reg.cmd == alle_pkg::CMD_DELETE)
                begin
                    q_next     = next_val;
                    rm_next    = d_rdata;
                    state_next = alle_pkg::S_W1;
                end
                else
                begin
                    fnext_next = next_val;
                    state_next = (cnt_reg == '0) ? alle_pkg::S_W1 : alle_pkg::S_RD3;
                end
            end

            alle_pkg::S_RD3:
            begin
                q_next     = next_val;
                state_next = alle_pkg::S_W1;
            end

            alle_pkg::S_W1:
            begin
                state_next = alle_pkg::S_W2;
                if (item_reg.cmd == alle_pkg::CMD_DELETE)
                begin
                    // unlink from both neighbors
                    if (q_reg != '0)
                    begin
                        p_we    = 1'b1;
                        p_waddr = alle_pkg::slot_addr(q_reg);
                        p_wdata = p_reg;
                    end
                    else
                    begin
                        tail_next = p_reg;
                    end
                    if (p_reg != '0)
                    begin
                        n_we    = 1'b1;
                        n_waddr = alle_pkg::slot_addr(p_reg);
                        n_wdata = q_reg;
                        nwr_next[alle_pkg::slot_addr(p_reg)] = 1'b1;
                    end
                    else
                    begin
                        head_next = q_reg;
                    end
                end
                else
                begin
                    d_we    = 1'b1;
                    d_waddr = alle_pkg::slot_addr(n_reg);
                    n_we    = 1'b1;
                    n_waddr = alle_pkg::slot_addr(n_reg);
                    p_we    = 1'b1;
                    p_waddr = alle_pkg::slot_addr(n_reg);
                    nwr_next[alle_pkg::slot_addr(n_reg)] = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        n_wdata    = '0;
                        p_wdata    = '0;
                        head_next  = n_reg;
                        tail_next  = n_reg;
                        free_next  = fnext_reg;
                        cnt_next   = cnt_reg + PW'(1);
                        used_next[alle_pkg::slot_addr(n_reg)] = 1'b1;
                        rs_next    = n_reg;
                        state_next = alle_pkg::S_DONE;
                    end
                    else if (item_reg.cmd == alle_pkg::CMD_INS_BEFORE)
                    begin
                        n_wdata = item_reg.slot;
                        p_wdata = p_reg;
                    end
                    else
                    begin
                        n_wdata = q_reg;
                        p_wdata = item_reg.slot;
                    end
                end
            end

            alle_pkg::S_W2:
            begin
                state_next = alle_pkg::S_DONE;
                if (item_reg.cmd == alle_pkg::CMD_DELETE)
                begin
                    n_we      = 1'b1;
                    n_waddr   = taddr;
                    n_wdata   = free_reg;
                    nwr_next[taddr]  = 1'b1;
                    used_next[taddr] = 1'b0;
                    free_next = item_reg.slot;
                    cnt_next  = cnt_reg - PW'(1);
                    rs_next   = item_reg.slot;
                end
                else
                begin
                    free_next = fnext_reg;
                    cnt_next  = cnt_reg + PW'(1);
                    used_next[alle_pkg::slot_addr(n_reg)] = 1'b1;
                    rs_next   = n_reg;
                    if (item_reg.cmd == alle_pkg::CMD_INS_BEFORE)
                    begin
                        p_we    = 1'b1;
                        p_waddr = taddr;
                        p_wdata = n_reg;
                        if (p_reg != '0)
                        begin
                            n_we    = 1'b1;
                            n_waddr = alle_pkg::slot_addr(p_reg);
                            n_wdata = n_reg;
                            nwr_next[alle_pkg::slot_addr(p_reg)] = 1'b1;
                        end
                        else
                        begin
                            head_next = n_reg;
                        end
                    end
                    else
                    begin
                        n_we    = 1'b1;
                        n_waddr = taddr;
                        n_wdata = n_reg;
                        nwr_next[taddr] = 1'b1;
                        if (q_reg != '0)
                        begin
                            p_we    = 1'b1;
                            p_waddr = alle_pkg::slot_addr(q_reg);
                            p_wdata = n_reg;
                        end
                        else
                        begin
                            tail_next = n_reg;
                        end
                    end
                end
            end

            alle_pkg::S_SR_ISSUE:
            begin
                d_raddr = alle_pkg::slot_addr(cur_reg);
                n_raddr = alle_pkg::slot_addr(cur_reg);
                if (cur_reg == '0 || cur_reg > PW'(alle_pkg::SLOTS) ||
                    !used_reg[alle_pkg::slot_addr(cur_reg)] ||
                    steps_reg == PW'(alle_pkg::SLOTS))
                begin
                    st_next    = alle_pkg::ST_NOT_FOUND;
                    rs_next    = '0;
                    state_next = alle_pkg::S_DONE;
                end
                else
                begin
                    state_next = alle_pkg::S_SR_CMP;
                end
            end

            alle_pkg::S_SR_CMP:
            begin
                if (d_rdata == item_reg.value)
                begin
                    st_next    = alle_pkg::ST_OK;
                    rs_next    = cur_reg;
                    state_next = alle_pkg::S_DONE;
                end
                else
                begin
                    cur_next   = next_val;
                    steps_next = steps_reg + PW'(1);
                    state_next = alle_pkg::S_SR_ISSUE;
                end
            end

            alle_pkg::S_DONE:
            begin
                if (!res_valid_reg || pop)
                begin
                    res_next.status  = st_reg;
                    res_next.rslot   = rs_reg;
                    res_next.removed = rm_reg;
                    res_next.count   = cnt_reg;
                    res_next.head    = head_reg;
                    res_next.tail    = tail_reg;
                    res_valid_next   = 1'b1;
                    state_next       = alle_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = alle_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= alle_pkg::S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= PW'(1);
            cnt_reg       <= '0;
            used_reg      <= '0;
            nwr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            cnt_reg       <= cnt_next;
            used_reg      <= used_next;
            nwr_reg       <= nwr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        n_reg     <= n_next;
        p_reg     <= p_next;
        q_reg     <= q_next;
        fnext_reg <= fnext_next;
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        st_reg    <= st_next;
        rs_reg    <= rs_next;
        rm_reg    <= rm_next;
        nra_reg   <= n_raddr;
        res_reg   <= res_next;
    end

endmodule

// ----- rtl/core/array_linked_list_engine_core.sv -----
// doubly linked list engine over a store of 64 slots numbered 1 to 64, with a free list
// input side is a queue: drive command, slot and value, raise push; the transaction
// is taken at a clock edge where push is high and full is low. two commands can wait
// result side is a single register: while empty is low the held result is on the ports,
// pop at an edge with empty low takes that transaction
// one result per command, in command order
// the steps follow from the single read port of each slot ram: insert and delete
//   read the rams, then write the links and the free list; errors go straight to the result;
//   search reads and compares one list element at a time from the head (up to 64 elements)
// commands are executed one at a time; a new command enters the input queue
// while the executor works or while a result waits to be popped
// when the receiver stalls the finished result is held in the output register,
// the executor holds the next one, and full rises once the input queue fills
// after reset the list is empty, the free list runs 1 to 64 and full is low
module array_linked_list_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [6:0]  slot,
    input  logic signed [31:0] value,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [6:0]  result_slot,
    output logic signed [31:0] removed_value,
    output logic [6:0]  count,
    output logic [6:0]  first_slot,
    output logic [6:0]  last_slot
);

    logic                item_valid;
    logic                item_take;
    alle_pkg::item_t     item;
    logic                res_valid;
    alle_pkg::result_t   res;

    alle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .command    (command),
        .slot       (slot),
        .value      (value),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    alle_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_valid  (res_valid),
        .res        (res),
        .pop        (pop)
    );

    assign empty         = !res_valid;
    assign status        = res.status;
    assign result_slot   = res.rslot;
    assign removed_value = res.removed;
    assign count         = res.count;
    assign first_slot    = res.head;
    assign last_slot     = res.tail;

endmodule

// ----- rtl/core/alle_checker.sv -----
module alle_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  command,
    input  logic [6:0]  slot,
    input  logic [31:0] value,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  status,
    input  logic [6:0]  result_slot,
    input  logic [31:0] removed_value,
    input  logic [6:0]  count,
    input  logic [6:0]  first_slot,
    input  logic [6:0]  last_slot
);

    logic unused_in;
    assign unused_in = push ^ full ^ pop ^ (^command) ^ (^slot) ^ (^value);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> count <= 7'(alle_pkg::SLOTS))
        else $error("count above store size");

    a_empty_list: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && count == '0) |-> (first_slot == '0 && last_slot == '0))
        else $error("empty list with head or tail");

    a_nonempty_list: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && count != '0) |-> (first_slot != '0 && last_slot != '0))
        else $error("list with no head or tail");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == alle_pkg::ST_FULL) |->
        (count == 7'(alle_pkg::SLOTS) && result_slot == '0))
        else $error("store full reported on a store with room");

    a_removed_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != alle_pkg::ST_OK) |-> (removed_value == '0 && unused_in == unused_in))
        else $error("removed value on a failed transaction");

endmodule

bind array_linked_list_engine_core alle_checker u_alle_checker (.*);
